// File: hw/rtl/mep_pkg.sv
// Package for the Mandelbrot escape-time pixel block: constants, codes, types and helpers.
package mep_pkg;

	localparam int FRAC_BITS_DEF = 25;
	localparam int MAX_ITER_DEF  = 10000;

	localparam int COORD_W = 32;
	localparam int STEP_W  = 31;
	localparam int PIX_W   = 12;
	localparam int LIMIT_W = 14;
	localparam int COUNT_W = 14;
	localparam int COLOR_W = 8;
	localparam int PROD_W  = 2 * COORD_W;
	localparam int IDX_W   = 3;
	localparam int QUOT_W  = 3;
	// Scaled count 255*k needs the limit width plus eight bits.
	localparam int DIVD_W  = LIMIT_W + COLOR_W;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 56;

	localparam logic [COLOR_W-1:0] COLOR_MAX = 8'd255;

	localparam logic signed [COORD_W-1:0] X_ORIGIN_RST = -32'sd73819750;
	localparam logic signed [COORD_W-1:0] Y_ORIGIN_RST = -32'sd50331648;
	localparam logic [STEP_W-1:0]         X_STEP_RST   = 31'd503316;
	localparam logic [STEP_W-1:0]         Y_STEP_RST   = 31'd503316;
	localparam logic [LIMIT_W-1:0]        ITER_LIM_RST = 14'd100;

	typedef enum logic [IDX_W-1:0] {
		REG_X_ORIGIN  = 3'd0,
		REG_Y_ORIGIN  = 3'd1,
		REG_X_STEP    = 3'd2,
		REG_Y_STEP    = 3'd3,
		REG_ITER_LIM  = 3'd4
	} reg_index_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CX,
		S_CY,
		S_CIM,
		S_RR,
		S_II,
		S_RI,
		S_UPD,
		S_DIV,
		S_DONE
	} state_t;

	// Clamp a wide signed value into the 32-bit coordinate range.
	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W:0] v);
		logic signed [PROD_W:0] hi;
		logic signed [PROD_W:0] lo;
		hi = $signed({{(PROD_W-COORD_W+2){1'b0}}, {(COORD_W-1){1'b1}}});
		lo = $signed({{(PROD_W-COORD_W+2){1'b1}}, {(COORD_W-1){1'b0}}});
		if (v > hi) begin
			sat32 = hi[COORD_W-1:0];
		end else if (v < lo) begin
			sat32 = lo[COORD_W-1:0];
		end else begin
			sat32 = v[COORD_W-1:0];
		end
	endfunction

endpackage

// File: hw/rtl/mandelbrot_escape_pixel_top.sv
// Mandelbrot escape-time evaluator for one pixel per item, built around one shared multiplier.
//
// Each input item carries a pixel column and row. The block forms c from the configured
// origin and steps, iterates w = w*w + c from w = c until |w|^2 exceeds 16 or the
// iteration limit is reached, and returns the count, an escaped flag and a green/blue
// color. All products go through a single 32x32 signed multiplier, so one iteration
// takes three products and an update. An escaping item also runs a bit-serial division
// for the color. The input is ready only while no item is in work, but a new item
// may be taken while the previous result still waits on the output register.
module mandelbrot_escape_pixel_top #(
	parameter int FRAC_BITS = mep_pkg::FRAC_BITS_DEF,
	parameter int MAX_ITER  = mep_pkg::MAX_ITER_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mep_pkg::IDX_W-1:0]           cfg_index,
	input  logic [mep_pkg::COORD_W-1:0]         cfg_data,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [11:0] pixel_column, [23:12] pixel_row
	input  logic [mep_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [11:0] out_column, [23:12] out_row, [37:24] iteration_count,
	// [45:38] green_level, [53:46] blue_level, [55:54] zero
	output logic [mep_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// [0] escaped
	output logic                                m_axis_tuser
);
	import mep_pkg::*;

	localparam logic [PROD_W-1:0] BOUND = PROD_W'(16) << (2 * FRAC_BITS);
	localparam logic [LIMIT_W+2:0] MAX_ITER_W = (LIMIT_W+3)'(MAX_ITER);

	// Configuration registers
	logic signed [COORD_W-1:0] x_origin_q;
	logic signed [COORD_W-1:0] y_origin_q;
	logic [STEP_W-1:0]         x_step_q;
	logic [STEP_W-1:0]         y_step_q;
	logic [LIMIT_W-1:0]        iter_lim_q;

	state_t state_q;
	state_t state_d;

	// Working registers
	logic [PIX_W-1:0]          col_q;
	logic [PIX_W-1:0]          row_q;
	logic [LIMIT_W-1:0]        lim_q;
	logic signed [COORD_W-1:0] cre_q;
	logic signed [COORD_W-1:0] cim_q;
	logic signed [COORD_W-1:0] wre_q;
	logic signed [COORD_W-1:0] wim_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [PROD_W-1:0]  rr_q;
	logic signed [PROD_W-1:0]  diff_q;
	logic [PROD_W-1:0]         sum_q;
	logic [COUNT_W-1:0]        cnt_q;
	logic                      esc_q;
	logic [DIVD_W-1:0]         rem_q;
	logic [COLOR_W-1:0]        quo_q;
	logic [QUOT_W-1:0]         bit_q;

	logic                      out_valid_q;
	logic [OUT_DATA_W-1:0]     out_data_q;
	logic                      out_user_q;

	// Shared multiplier
	logic signed [COORD_W-1:0] mul_a;
	logic signed [COORD_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_p;

	logic                      in_take;
	logic                      out_load;
	logic                      escape_now;
	logic                      last_iter;
	logic [DIVD_W-1:0]         div_sub;
	logic signed [PROD_W-1:0]  re_shift;
	logic signed [PROD_W-1:0]  im_shift;
	logic [COLOR_W-1:0]        green;
	logic [COLOR_W-1:0]        blue;
	logic [LIMIT_W-1:0]        lim_eff;

	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	assign in_take    = s_axis_tvalid && s_axis_tready;
	assign mul_p      = mul_a * mul_b;
	assign escape_now = sum_q > BOUND;
	assign last_iter  = ({1'b0, cnt_q} + (COUNT_W+1)'(1)) == {1'b0, lim_q};
	assign div_sub    = {{COLOR_W{1'b0}}, lim_q} << bit_q;
	assign re_shift   = diff_q >>> FRAC_BITS;
	assign im_shift   = prod_q >>> (FRAC_BITS - 1);
	assign blue       = esc_q ? quo_q : '0;
	assign green      = esc_q ? (COLOR_MAX - quo_q) : '0;
	assign lim_eff    = ({3'b000, iter_lim_q} > MAX_ITER_W) ? MAX_ITER_W[LIMIT_W-1:0]
	                                                        : iter_lim_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q <= X_ORIGIN_RST;
			y_origin_q <= Y_ORIGIN_RST;
			x_step_q   <= X_STEP_RST;
			y_step_q   <= Y_STEP_RST;
			iter_lim_q <= ITER_LIM_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_X_ORIGIN: x_origin_q <= cfg_data;
				REG_Y_ORIGIN: y_origin_q <= cfg_data;
				REG_X_STEP:   x_step_q   <= cfg_data[STEP_W-1:0];
				REG_Y_STEP:   y_step_q   <= cfg_data[STEP_W-1:0];
				REG_ITER_LIM: iter_lim_q <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_take) state_d = S_CX;
			S_CX:   state_d = S_CY;
			S_CY:   state_d = S_CIM;
			S_CIM:  state_d = (lim_q == '0) ? S_DONE : S_II;
			S_RR:   state_d = S_II;
			S_II:   state_d = S_RI;
			S_RI:   state_d = S_UPD;
			S_UPD: begin
				if (escape_now) begin
					state_d = S_DIV;
				end else if (last_iter) begin
					state_d = S_DONE;
				end else begin
					state_d = S_RR;
				end
			end
			S_DIV:  if (bit_q == '0) state_d = S_DONE;
			S_DONE: if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// State outputs: handshake and multiplier operand selection
	always_comb begin
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		mul_a         = wre_q;
		mul_b         = wre_q;
		unique case (state_q)
			S_IDLE: s_axis_tready = 1'b1;
			S_CX: begin
				mul_a = $signed({{(COORD_W-PIX_W){1'b0}}, col_q});
				mul_b = $signed({1'b0, x_step_q});
			end
			S_CY: begin
				mul_a = $signed({{(COORD_W-PIX_W){1'b0}}, row_q});
				mul_b = $signed({1'b0, y_step_q});
			end
			S_CIM, S_RR: begin
				mul_a = wre_q;
				mul_b = wre_q;
			end
			S_II: begin
				mul_a = wim_q;
				mul_b = wim_q;
			end
			S_RI: begin
				mul_a = wre_q;
				mul_b = wim_q;
			end
			S_DONE: out_load = !out_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		unique case (state_q)
			S_IDLE: begin
				col_q <= s_axis_tdata[PIX_W-1:0];
				row_q <= s_axis_tdata[2*PIX_W-1:PIX_W];
				lim_q <= lim_eff;
			end
			S_CX: begin
				cnt_q <= '0;
				esc_q <= 1'b0;
			end
			S_CY: begin
				cre_q <= sat32($signed({{(PROD_W-COORD_W+1){x_origin_q[COORD_W-1]}}, x_origin_q})
				             + $signed({prod_q[PROD_W-1], prod_q}));
				wre_q <= sat32($signed({{(PROD_W-COORD_W+1){x_origin_q[COORD_W-1]}}, x_origin_q})
				             + $signed({prod_q[PROD_W-1], prod_q}));
			end
			S_CIM: begin
				cim_q <= sat32($signed({{(PROD_W-COORD_W+1){y_origin_q[COORD_W-1]}}, y_origin_q})
				             + $signed({prod_q[PROD_W-1], prod_q}));
				wim_q <= sat32($signed({{(PROD_W-COORD_W+1){y_origin_q[COORD_W-1]}}, y_origin_q})
				             + $signed({prod_q[PROD_W-1], prod_q}));
			end
			S_II: rr_q <= prod_q;
			S_RI: begin
				// Both squares are non-negative, so the unsigned sum cannot wrap.
				sum_q  <= rr_q + prod_q;
				diff_q <= rr_q - prod_q;
			end
			S_UPD: begin
				if (escape_now) begin
					esc_q <= 1'b1;
					rem_q <= {cnt_q, {COLOR_W{1'b0}}} - {{COLOR_W{1'b0}}, cnt_q};
					quo_q <= '0;
					bit_q <= '1;
				end else begin
					cnt_q <= cnt_q + COUNT_W'(1);
					wre_q <= sat32($signed({re_shift[PROD_W-1], re_shift})
					             + $signed({{(PROD_W-COORD_W+1){cre_q[COORD_W-1]}}, cre_q}));
					wim_q <= sat32($signed({im_shift[PROD_W-1], im_shift})
					             + $signed({{(PROD_W-COORD_W+1){cim_q[COORD_W-1]}}, cim_q}));
				end
			end
			S_DIV: begin
				// Restoring division, one quotient bit per cycle from the top.
				if (rem_q >= div_sub) begin
					rem_q        <= rem_q - div_sub;
					quo_q[bit_q] <= 1'b1;
				end
				bit_q <= bit_q - QUOT_W'(1);
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {2'b00, blue, green, cnt_q, row_q, col_q};
			out_user_q <= esc_q;
		end
	end

endmodule

// File: bench/tb_mandelbrot_escape_pixel_top.sv
// Self-checking testbench for the Mandelbrot escape-time pixel block with its own predictor.
module tb_mandelbrot_escape_pixel_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mep_pkg::*;

	typedef struct {
		logic [PIX_W-1:0]   column;
		logic [PIX_W-1:0]   row;
		logic [COUNT_W-1:0] rounds;
		logic               escaped;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} pixel_result_t;

	class escape_scoreboard;
		logic signed [COORD_W-1:0] x_org;
		logic signed [COORD_W-1:0] y_org;
		logic [STEP_W-1:0]         x_inc;
		logic [STEP_W-1:0]         y_inc;
		logic [LIMIT_W-1:0]        max_rounds;
		pixel_result_t             awaited[$];
		int                        mismatches;

		function new();
			x_org = X_ORIGIN_RST;
			y_org = Y_ORIGIN_RST;
			x_inc = X_STEP_RST;
			y_inc = Y_STEP_RST;
			max_rounds = ITER_LIM_RST;
			mismatches = 0;
		endfunction

		static function longint clamp32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [COORD_W-1:0] val);
			case (idx)
				REG_X_ORIGIN: x_org = val;
				REG_Y_ORIGIN: y_org = val;
				REG_X_STEP:   x_inc = val[STEP_W-1:0];
				REG_Y_STEP:   y_inc = val[STEP_W-1:0];
				REG_ITER_LIM: max_rounds = val[LIMIT_W-1:0];
				default: ;
			endcase
		endfunction

		function pixel_result_t escape_time(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
			longint cre, cim, wre, wim, rr, ii, ri, nre, col_l, row_l;
			longint unsigned sumsq, bound;
			int rounds, k, f;
			pixel_result_t r;
			col_l = col;
			row_l = row;
			bound = 64'd16 << (2 * FRAC_BITS_DEF);
			rounds = max_rounds;
			if (rounds > MAX_ITER_DEF) rounds = MAX_ITER_DEF;
			cre = clamp32(longint'(x_org) + col_l * longint'(x_inc));
			cim = clamp32(longint'(y_org) + row_l * longint'(y_inc));
			wre = cre;
			wim = cim;
			k = 0;
			while (k < rounds) begin
				rr = wre * wre;
				ii = wim * wim;
				ri = wre * wim;
				// Two squares of -2^31 add up to 2^63, so the sum is compared unsigned.
				sumsq = rr + ii;
				if (sumsq > bound) break;
				nre = clamp32(((rr - ii) >>> FRAC_BITS_DEF) + cre);
				wim = clamp32((ri >>> (FRAC_BITS_DEF - 1)) + cim);
				wre = nre;
				k++;
			end
			r.column = col;
			r.row = row;
			r.rounds = k[COUNT_W-1:0];
			r.escaped = (k < rounds);
			r.green = '0;
			r.blue = '0;
			if (k < rounds) begin
				f = (255 * k) / rounds;
				r.green = COLOR_MAX - f[COLOR_W-1:0];
				r.blue = f[COLOR_W-1:0];
			end
			return r;
		endfunction

		function void note_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
			awaited.push_back(escape_time(col, row));
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] data, logic esc_flag);
			pixel_result_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result item: tdata %h tuser %b", data, esc_flag);
				end
				return;
			end
			want = awaited.pop_front();
			if (data[11:0] != want.column || data[23:12] != want.row
					|| data[37:24] != want.rounds || esc_flag != want.escaped
					|| data[45:38] != want.green || data[53:46] != want.blue
					|| data[55:54] != 2'b00) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("pixel (%0d,%0d) expected: count %0d esc %0b green %0d blue %0d",
						want.column, want.row, want.rounds, want.escaped, want.green,
						want.blue);
					$display("  actual: col %0d row %0d count %0d esc %0b green %0d blue %0d pad %0d",
						data[11:0], data[23:12], data[37:24], esc_flag, data[45:38],
						data[53:46], data[55:54]);
				end
			end
		endfunction
	endclass

	localparam int STALL_LIMIT = 200000;
	localparam logic [IDX_W-1:0] UNMAPPED_REG = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [IDX_W-1:0]      cfg_index = '0;
	logic [COORD_W-1:0]    cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;

	logic steady = 1'b0;
	int   stall_cycles = 0;
	escape_scoreboard board;

	always #2 clk = ~clk;

	mandelbrot_escape_pixel_top DUT (.*);

	always @(posedge clk) begin
		m_axis_tready <= steady || ($urandom_range(0, 99) >= 19);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			board.check_result(m_axis_tdata, m_axis_tuser);
		end
	end

	// Ends the run when no item moves on any channel for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.set_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_view(input logic [COORD_W-1:0] xo, input logic [COORD_W-1:0] yo,
			input logic [COORD_W-1:0] xs, input logic [COORD_W-1:0] ys,
			input logic [COORD_W-1:0] lim);
		int first;
		reg_index_t r;
		first = $urandom_range(0, 4);
		for (int i = 0; i < 5; i++) begin
			r = reg_index_t'((first + i) % 5);
			case (r)
				REG_X_ORIGIN: write_reg(r, xo);
				REG_Y_ORIGIN: write_reg(r, yo);
				REG_X_STEP:   write_reg(r, xs);
				REG_Y_STEP:   write_reg(r, ys);
				default:      write_reg(r, lim);
			endcase
		end
	endtask

	// Leaves tvalid high after the handshake so back-to-back items need no second assignment.
	task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
		if (!steady) begin
			while ($urandom_range(0, 99) < 19) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {row, col};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		board.note_pixel(col, row);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (board.awaited.size() != 0);
	endtask

	initial begin
		logic [PIX_W-1:0] col, row;
		board = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset view: corners and one pixel inside the set.
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd100, 12'd100);
		wait_drained();

		// Zero limit: no round at all, black; a write to an unmapped index changes nothing.
		load_view(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		write_reg(UNMAPPED_REG, $urandom);
		send_pixel(12'd7, 12'd9);
		wait_drained();

		// Unit steps on the real axis with a limit of three.
		write_reg(REG_X_STEP, 32'd33554432);
		write_reg(REG_ITER_LIM, 32'd3);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd1, 12'd0);
		send_pixel(12'd2, 12'd0);
		send_pixel(12'd5, 12'd0);
		wait_drained();

		// Saturated c, including both parts at the most negative value.
		load_view(32'h80000000, 32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h3FFF);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd0, 12'd4095);
		wait_drained();
		write_reg(REG_X_ORIGIN, 32'h7FFFFFFF);
		send_pixel(12'd0, 12'd0);
		wait_drained();

		// Limit above the maximum: c = -2 never escapes, c = 4 sits exactly on the bound.
		load_view(-32'sd67108864, 32'd0, 32'd100663296, 32'd0, 32'd16383);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd2, 12'd0);
		send_pixel(12'd1, 12'd0);
		wait_drained();

		for (int phase = 0; phase < 8; phase++) begin
			steady <= (phase == 2);
			if (phase % 3 == 1) begin
				load_view($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 16383));
			end else begin
				load_view(-32'sd83886080 + $urandom_range(0, 100663296),
					-32'sd50331648 + $urandom_range(0, 100663296),
					$urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20),
					$urandom_range(1, 200));
			end
			for (int i = 0; i < 88; i++) begin
				if ($urandom_range(0, 3) == 0) begin
					col = $urandom_range(0, 4095);
					row = $urandom_range(0, 4095);
				end else begin
					col = $urandom_range(0, 63);
					row = $urandom_range(0, 63);
				end
				send_pixel(col, row);
				if ($urandom_range(0, 59) == 0) wait_drained();
			end
			wait_drained();
		end

		repeat (60) @(posedge clk);
		if (board.mismatches == 0 && board.awaited.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
